>>> design/rsi_pkg.sv
// ---------------------------------------------------------------------------
// rsi_pkg: shared types and codes for the ray/sphere intersection core
// Configuration register indexes and the per-item flag group that travels
// down the pipeline next to the arithmetic data.
// ---------------------------------------------------------------------------
package rsi_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SPHERE_X      = 2'd0,
        CFG_SPHERE_Y      = 2'd1,
        CFG_SPHERE_Z      = 2'd2,
        CFG_SPHERE_RADIUS = 2'd3
    } cfg_index_t;

    // per-item status carried alongside the data
    typedef struct packed {
        logic hit;
        logic degenerate;
    } ray_flags_t;

endpackage

>>> design/rsi_sqrt.sv
// ---------------------------------------------------------------------------
// rsi_sqrt: pipelined integer square root
// Restoring digit-by-digit floor square root, one root bit per register
// stage. A side word rides along with each item. Stages advance on en.
// ---------------------------------------------------------------------------
module rsi_sqrt #(
    parameter int RAD_W  = 136,
    parameter int SIDE_W = 8,
    localparam int ROOT_W = RAD_W / 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int REM_W = ROOT_W + 2;

    logic              vld_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_step
        logic              src_vld;
        logic [RAD_W-1:0]  src_rad;
        logic [REM_W-1:0]  src_rem;
        logic [ROOT_W-1:0] src_root;
        logic [SIDE_W-1:0] src_side;
        logic [REM_W-1:0]  cur_val;
        logic [REM_W-1:0]  trial;
        logic              take;

        if (i == 0) begin : g_first
            assign src_vld  = in_valid;
            assign src_rad  = in_rad;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_side = in_side;
        end else begin : g_chain
            assign src_vld  = vld_reg[i-1];
            assign src_rad  = rad_reg[i-1];
            assign src_rem  = rem_reg[i-1];
            assign src_root = root_reg[i-1];
            assign src_side = side_reg[i-1];
        end

        // bring down the next two radicand bits, try root*4+1
        always_comb begin
            cur_val = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
            trial   = {src_root, 2'b01};
            take    = (cur_val >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[i]  <= src_rad << 2;
                rem_reg[i]  <= take ? (cur_val - trial) : cur_val;
                root_reg[i] <= {src_root[ROOT_W-2:0], take};
                side_reg[i] <= src_side;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

>>> design/rsi_div.sv
// ---------------------------------------------------------------------------
// rsi_div: pipelined two-lane signed divide with saturation
// Divides two signed numerators by one shared positive divisor, truncating
// toward zero, one quotient bit per long-division stage, and saturates to QUO_W bits.
// ---------------------------------------------------------------------------
module rsi_div #(
    parameter int NUM_W  = 84,
    parameter int DEN_W  = 64,
    parameter int QUO_W  = 32,
    parameter int SIDE_W = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] in_num_far,
    input  logic signed [NUM_W-1:0] in_num_near,
    input  logic [DEN_W-1:0]        in_den,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic signed [QUO_W-1:0] out_q_far,
    output logic signed [QUO_W-1:0] out_q_near,
    output logic                    out_clip_far,
    output logic                    out_clip_near,
    output logic [SIDE_W-1:0]       out_side
);

    localparam int REM_W = DEN_W + 1;
    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = NUM_W + DEN_W;
    localparam logic [QUO_W-1:0] MAX_POS = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] MIN_MAG = {1'b1, {(QUO_W-1){1'b0}}};

    logic signed [NUM_W-1:0] num_in [2];
    assign num_in[0] = in_num_far;
    assign num_in[1] = in_num_near;

    // stage A: sign and magnitude
    logic              va_reg;
    logic [NUM_W-1:0]  mag_a_reg [2];
    logic              neg_a_reg [2];
    logic [DEN_W-1:0]  den_a_reg;
    logic [SIDE_W-1:0] side_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                neg_a_reg[l] <= num_in[l][NUM_W-1];
                mag_a_reg[l] <= num_in[l][NUM_W-1] ? NUM_W'(-num_in[l]) : NUM_W'(num_in[l]);
            end
            den_a_reg  <= in_den;
            side_a_reg <= in_side;
        end
    end

    // stage B: overflow check on the high part, seed the remainder
    logic              vb_reg;
    logic [QUO_W-1:0]  low_b_reg [2];
    logic [REM_W-1:0]  rem_b_reg [2];
    logic              ovf_b_reg [2];
    logic              neg_b_reg [2];
    logic [DEN_W-1:0]  den_b_reg;
    logic [SIDE_W-1:0] side_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                low_b_reg[l] <= mag_a_reg[l][QUO_W-1:0];
                rem_b_reg[l] <= REM_W'(mag_a_reg[l][NUM_W-1 -: HI_W]);
                ovf_b_reg[l] <= CMP_W'(mag_a_reg[l][NUM_W-1 -: HI_W]) >= CMP_W'(den_a_reg);
                neg_b_reg[l] <= neg_a_reg[l];
            end
            den_b_reg  <= den_a_reg;
            side_b_reg <= side_a_reg;
        end
    end

    // long division, one quotient bit per stage
    logic              vq_reg   [QUO_W];
    logic [QUO_W-1:0]  low_reg  [QUO_W][2];
    logic [REM_W-1:0]  rem_reg  [QUO_W][2];
    logic [QUO_W-1:0]  quo_reg  [QUO_W][2];
    logic              ovf_reg  [QUO_W][2];
    logic              neg_reg  [QUO_W][2];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_bit
        logic              src_vld;
        logic [QUO_W-1:0]  src_low  [2];
        logic [REM_W-1:0]  src_rem  [2];
        logic [QUO_W-1:0]  src_quo  [2];
        logic              src_ovf  [2];
        logic              src_neg  [2];
        logic [DEN_W-1:0]  src_den;
        logic [SIDE_W-1:0] src_side;
        logic [REM_W-1:0]  cur_val  [2];
        logic              take     [2];

        if (i == 0) begin : g_first
            assign src_vld  = vb_reg;
            assign src_low  = low_b_reg;
            assign src_rem  = rem_b_reg;
            assign src_quo  = '{default: '0};
            assign src_ovf  = ovf_b_reg;
            assign src_neg  = neg_b_reg;
            assign src_den  = den_b_reg;
            assign src_side = side_b_reg;
        end else begin : g_chain
            assign src_vld  = vq_reg[i-1];
            assign src_low  = low_reg[i-1];
            assign src_rem  = rem_reg[i-1];
            assign src_quo  = quo_reg[i-1];
            assign src_ovf  = ovf_reg[i-1];
            assign src_neg  = neg_reg[i-1];
            assign src_den  = den_reg[i-1];
            assign src_side = side_reg[i-1];
        end

        // shift in the next numerator bit and try one subtract per lane
        always_comb begin
            for (int l = 0; l < 2; l++) begin
                cur_val[l] = {src_rem[l][REM_W-2:0], src_low[l][QUO_W-1]};
                take[l]    = (cur_val[l] >= {1'b0, src_den});
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vq_reg[i] <= 1'b0;
            end else if (en) begin
                vq_reg[i] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < 2; l++) begin
                    low_reg[i][l] <= src_low[l] << 1;
                    rem_reg[i][l] <= take[l] ? (cur_val[l] - {1'b0, src_den}) : cur_val[l];
                    quo_reg[i][l] <= {src_quo[l][QUO_W-2:0], take[l]};
                    ovf_reg[i][l] <= src_ovf[l];
                    neg_reg[i][l] <= src_neg[l];
                end
                den_reg[i]  <= src_den;
                side_reg[i] <= src_side;
            end
        end
    end

    // final: saturate, restore sign
    logic              vo_reg;
    logic [QUO_W-1:0]  qo_reg   [2];
    logic              clip_reg [2];
    logic [SIDE_W-1:0] side_o_reg;
    logic [QUO_W-1:0]  q_fin    [2];
    logic              clip_fin [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            clip_fin[l] = ovf_reg[QUO_W-1][l] ||
                          (neg_reg[QUO_W-1][l] ? (quo_reg[QUO_W-1][l] > MIN_MAG)
                                               : (quo_reg[QUO_W-1][l] > MAX_POS));
            if (clip_fin[l]) begin
                q_fin[l] = neg_reg[QUO_W-1][l] ? MIN_MAG : MAX_POS;
            end else begin
                q_fin[l] = neg_reg[QUO_W-1][l] ? (-quo_reg[QUO_W-1][l])
                                               : quo_reg[QUO_W-1][l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= vq_reg[QUO_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qo_reg     <= q_fin;
            clip_reg   <= clip_fin;
            side_o_reg <= side_reg[QUO_W-1];
        end
    end

    assign out_valid     = vo_reg;
    assign out_q_far     = signed'(qo_reg[0]);
    assign out_q_near    = signed'(qo_reg[1]);
    assign out_clip_far  = clip_reg[0];
    assign out_clip_near = clip_reg[1];
    assign out_side      = side_o_reg;

endmodule

>>> design/ray_sphere_intersection_core.sv
// Throughput: one item per cycle; stages hold only while a result waits behind a blocked output.
// Depth is set by the square root (2*COORD_WIDTH+FRAC_BITS+2 stages, one root bit each)
// and the divider (COORD_WIDTH+3 stages, one quotient bit per long-division stage).
// Reset: aresetn (sync, low) clears all valid bits; sphere center 0, radius 1.0.
// ---------------------------------------------------------------------------
// ray_sphere_intersection_core: fixed-point ray against sphere test
// Forms a = d.d, h = d.(o-s), c = |o-s|^2 - r^2 and D = h^2 - a*c, then both
// roots (-h +- sqrt(D)) / a in the coordinate format, saturated.
// ---------------------------------------------------------------------------
module ray_sphere_intersection_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int IN_W  = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_WIDTH + 3 + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_wdata,
    // ray items in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    // results out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata   // hit, degenerate, root_far, root_near, clipped
);

    localparam int CW   = COORD_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int EW   = CW + 1;
    localparam int DDW  = 2 * CW;
    localparam int DEW  = 2 * CW + 1;
    localparam int EEW  = 2 * CW + 2;
    localparam int RADW = CW - 1;
    localparam int RRW  = 2 * CW - 2;
    localparam int AW   = 2 * CW;
    localparam int HW   = 2 * CW + 2;
    localparam int CCW  = 2 * CW + 3;
    localparam int LH   = CW + 1;
    localparam int HHW  = HW - LH;
    localparam int LA   = CW;
    localparam int AHW  = AW - LA;
    localparam int LC   = CW + 1;
    localparam int CHW  = CCW - LC;
    localparam int PHH  = 2 * HHW;
    localparam int PHM  = HHW + LH + 1;
    localparam int PHL  = 2 * LH;
    localparam int PSS  = AHW + CHW + 1;
    localparam int PSU  = AHW + LC;
    localparam int PLS  = LA + CHW + 1;
    localparam int PLU  = LA + LC;
    localparam int DW   = 4 * CW + 4;
    localparam int RW   = 4 * CW + 2 * FB + 4;
    localparam int SW   = RW / 2;
    localparam int NW   = SW + 2;
    localparam int FLW  = $bits(rsi_pkg::ray_flags_t);
    localparam int SDW  = HW + AW + FLW;

    // -----------------------------------------------------------------------
    // configuration registers
    logic signed [CW-1:0] center_reg [3];
    logic [RADW-1:0]      radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= RADW'(1) << FB;
        end else if (cfg_wr_en) begin
            unique case (rsi_pkg::cfg_index_t'(cfg_index))
                rsi_pkg::CFG_SPHERE_X:      center_reg[0] <= signed'(cfg_wdata);
                rsi_pkg::CFG_SPHERE_Y:      center_reg[1] <= signed'(cfg_wdata);
                rsi_pkg::CFG_SPHERE_Z:      center_reg[2] <= signed'(cfg_wdata);
                rsi_pkg::CFG_SPHERE_RADIUS: radius_reg    <= cfg_wdata[RADW-1:0];
                default: ;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // flow control: stages move unless the output register is blocked and a result waits at the divider
    logic pipe_en;
    logic out_can;
    logic div_valid;
    logic m_valid_reg;

    assign out_can  = !m_valid_reg || m_tready;
    assign pipe_en  = out_can || !div_valid;
    assign s_tready = pipe_en;

    // -----------------------------------------------------------------------
    // stage 1: e = o - s
    logic                 v1_reg;
    logic signed [EW-1:0] e_reg [3];
    logic signed [CW-1:0] d_reg [3];
    logic signed [EW-1:0] e_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e_next[k] = EW'(signed'(s_tdata[k*CW +: CW])) - EW'(center_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                e_reg[k] <= e_next[k];
                d_reg[k] <= signed'(s_tdata[(3+k)*CW +: CW]);
            end
        end
    end

    // -----------------------------------------------------------------------
    // stage 2: per-axis products
    logic                  v2_reg;
    logic signed [DDW-1:0] dd_reg [3];
    logic signed [DEW-1:0] de_reg [3];
    logic signed [EEW-1:0] ee_reg [3];
    logic [RRW-1:0]        rr_reg;
    logic                  dg2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (pipe_en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                dd_reg[k] <= d_reg[k] * d_reg[k];
                de_reg[k] <= d_reg[k] * e_reg[k];
                ee_reg[k] <= e_reg[k] * e_reg[k];
            end
            rr_reg  <= radius_reg * radius_reg;
            dg2_reg <= (d_reg[0] == '0) && (d_reg[1] == '0) && (d_reg[2] == '0);
        end
    end

    // -----------------------------------------------------------------------
    // stage 3: a, h, c
    logic                  v3_reg;
    logic [AW-1:0]         a3_reg;
    logic signed [HW-1:0]  h3_reg;
    logic signed [CCW-1:0] c3_reg;
    logic                  dg3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (pipe_en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a3_reg  <= AW'(dd_reg[0]) + AW'(dd_reg[1]) + AW'(dd_reg[2]);
            h3_reg  <= HW'(de_reg[0]) + HW'(de_reg[1]) + HW'(de_reg[2]);
            c3_reg  <= CCW'(ee_reg[0]) + CCW'(ee_reg[1]) + CCW'(ee_reg[2])
                       - signed'(CCW'(rr_reg));
            dg3_reg <= dg2_reg;
        end
    end

    // -----------------------------------------------------------------------
    // stage 4: partial products of h*h and a*c
    logic                  v4_reg;
    logic signed [PHH-1:0] phh_reg;
    logic signed [PHM-1:0] phm_reg;
    logic [PHL-1:0]        phl_reg;
    logic signed [PSS-1:0] pss_reg;
    logic [PSU-1:0]        psu_reg;
    logic signed [PLS-1:0] pls_reg;
    logic [PLU-1:0]        plu_reg;
    logic signed [HW-1:0]  h4_reg;
    logic [AW-1:0]         a4_reg;
    logic                  dg4_reg;

    logic signed [HHW-1:0] h_hi;
    logic signed [LH:0]    h_lo_s;
    logic signed [AHW:0]   a_hi_s;
    logic signed [LA:0]    a_lo_s;
    logic signed [CHW-1:0] c_hi;

    assign h_hi   = h3_reg[HW-1 -: HHW];
    assign h_lo_s = signed'({1'b0, h3_reg[LH-1:0]});
    assign a_hi_s = signed'({1'b0, a3_reg[AW-1 -: AHW]});
    assign a_lo_s = signed'({1'b0, a3_reg[LA-1:0]});
    assign c_hi   = c3_reg[CCW-1 -: CHW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (pipe_en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            phh_reg <= h_hi * h_hi;
            phm_reg <= h_hi * h_lo_s;
            phl_reg <= h3_reg[LH-1:0] * h3_reg[LH-1:0];
            pss_reg <= a_hi_s * c_hi;
            psu_reg <= a3_reg[AW-1 -: AHW] * c3_reg[LC-1:0];
            pls_reg <= a_lo_s * c_hi;
            plu_reg <= a3_reg[LA-1:0] * c3_reg[LC-1:0];
            h4_reg  <= h3_reg;
            a4_reg  <= a3_reg;
            dg4_reg <= dg3_reg;
        end
    end

    // -----------------------------------------------------------------------
    // stage 5: combine partial products
    logic                 v5_reg;
    logic signed [DW-1:0] hsq_reg;
    logic signed [DW-1:0] ac_reg;
    logic signed [HW-1:0] h5_reg;
    logic [AW-1:0]        a5_reg;
    logic                 dg5_reg;
    logic signed [DW-1:0] hsq_next;
    logic signed [DW-1:0] ac_next;

    always_comb begin
        hsq_next = (DW'(phh_reg) <<< (2 * LH)) + (DW'(phm_reg) <<< (LH + 1))
                   + signed'(DW'(phl_reg));
        ac_next  = (DW'(pss_reg) <<< (LA + LC)) + (signed'(DW'(psu_reg)) <<< LA)
                   + (DW'(pls_reg) <<< LC) + signed'(DW'(plu_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (pipe_en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            hsq_reg <= hsq_next;
            ac_reg  <= ac_next;
            h5_reg  <= h4_reg;
            a5_reg  <= a4_reg;
            dg5_reg <= dg4_reg;
        end
    end

    // -----------------------------------------------------------------------
    // stage 6: quarter discriminant
    logic                 v6_reg;
    logic signed [DW-1:0] d6_reg;
    logic signed [HW-1:0] h6_reg;
    logic [AW-1:0]        a6_reg;
    logic                 dg6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (pipe_en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d6_reg  <= hsq_reg - ac_reg;
            h6_reg  <= h5_reg;
            a6_reg  <= a5_reg;
            dg6_reg <= dg5_reg;
        end
    end

    // -----------------------------------------------------------------------
    // square root of D * 2^(2*FB)
    rsi_pkg::ray_flags_t flags6;
    logic [RW-1:0]       sq_rad;
    logic [SDW-1:0]      sq_side_in;
    logic                sq_valid;
    logic [SW-1:0]       sq_root;
    logic [SDW-1:0]      sq_side;

    always_comb begin
        flags6.degenerate = dg6_reg;
        flags6.hit        = !dg6_reg && !d6_reg[DW-1];
        sq_rad            = d6_reg[DW-1] ? '0
                                         : RW'({d6_reg[DW-2:0], {(2 * FB){1'b0}}});
        sq_side_in        = {h6_reg, a6_reg, flags6};
    end

    rsi_sqrt #(
        .RAD_W  (RW),
        .SIDE_W (SDW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v6_reg),
        .in_rad    (sq_rad),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // -----------------------------------------------------------------------
    // numerators: +-S - h * 2^FB
    logic                 vn_reg;
    logic signed [NW-1:0] nf_reg;
    logic signed [NW-1:0] nn_reg;
    logic [AW-1:0]        an_reg;
    logic [FLW-1:0]       fln_reg;
    logic signed [NW-1:0] hs_ext;
    logic signed [NW-1:0] s_ext;

    assign hs_ext = NW'(signed'(sq_side[SDW-1 -: HW])) <<< FB;
    assign s_ext  = signed'(NW'(sq_root));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vn_reg <= 1'b0;
        end else if (pipe_en) begin
            vn_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            nf_reg  <= s_ext - hs_ext;
            nn_reg  <= -s_ext - hs_ext;
            an_reg  <= sq_side[FLW +: AW];
            fln_reg <= sq_side[FLW-1:0];
        end
    end

    // -----------------------------------------------------------------------
    // divide both numerators by a
    logic signed [CW-1:0] q_far;
    logic signed [CW-1:0] q_near;
    logic                 clip_far;
    logic                 clip_near;
    logic [FLW-1:0]       div_side;

    rsi_div #(
        .NUM_W  (NW),
        .DEN_W  (AW),
        .QUO_W  (CW),
        .SIDE_W (FLW)
    ) u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (pipe_en),
        .in_valid      (vn_reg),
        .in_num_far    (nf_reg),
        .in_num_near   (nn_reg),
        .in_den        (an_reg),
        .in_side       (fln_reg),
        .out_valid     (div_valid),
        .out_q_far     (q_far),
        .out_q_near    (q_near),
        .out_clip_far  (clip_far),
        .out_clip_near (clip_near),
        .out_side      (div_side)
    );

    // -----------------------------------------------------------------------
    // output register: mask roots when there is no hit
    rsi_pkg::ray_flags_t flags_o;
    logic [OUT_W-1:0]    m_data_reg;
    logic [OUT_W-1:0]    m_data_next;

    always_comb begin
        flags_o     = rsi_pkg::ray_flags_t'(div_side);
        m_data_next = '0;
        m_data_next[0]             = flags_o.hit;
        m_data_next[1]             = flags_o.degenerate;
        m_data_next[2 +: CW]       = flags_o.hit ? q_far : '0;
        m_data_next[2 + CW +: CW]  = flags_o.hit ? q_near : '0;
        m_data_next[2 + 2 * CW]    = flags_o.hit && (clip_far || clip_near);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_can) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_can) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // -----------------------------------------------------------------------
    // checks
    a_hit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("hit and degenerate both set");

    a_nohit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |->
            (m_tdata[2 +: CW] == '0) && (m_tdata[2 + CW +: CW] == '0) && !m_tdata[2 + 2 * CW])
        else $error("roots or clip set without a hit");

    a_ready_only_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && div_valid))
        else $error("input stalled while output path is free");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> (2 * CW + 3)) == '0)
        else $error("padding bits of result not zero");

endmodule
